FILE: rtl/rrps_pkg.sv
// Shared commands, field widths and types for the round-robin poll scheduler.
package rrps_pkg;

    localparam int CMD_W   = 2;
    localparam int PID_W   = 5;
    localparam int COUNT_W = 8;
    // Shared adder width: covers a count or a probe index plus one, up to 256.
    localparam int ADD_W   = 9;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [ADD_W-1:0]   t_sum;

    localparam t_cmd CMD_SUBSCRIBE   = 2'd0;
    localparam t_cmd CMD_UNSUBSCRIBE = 2'd1;
    localparam t_cmd CMD_POLL        = 2'd2;

    localparam t_count COUNT_MAX = 8'd255;

endpackage

FILE: rtl/rrps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/refcounted_round_robin_poll_scheduler.sv
// Subscriber counts per poll identifier with a round-robin poll grant, one result word per input word.
// Subscribe and unsubscribe words pass from acceptance through the count RAM read, the update and
// write back, and the output load; a bad command or an identifier out of range goes straight to
// the output load. A poll probes up to PID_COUNT identifiers, one per cycle through the nonzero-flag
// vector, and then loads the output. One 9-bit adder does the poll start step from the last grant,
// the count step and the probe increment. The input side is ready only while the sequencer is
// idle; a finished word can wait in the output register while the next input word is taken.
// Counts live in a RAM; a per-identifier nonzero flag cleared by reset makes every count read
// as zero after reset, so no clearing pass is needed.
module refcounted_round_robin_poll_scheduler
    import rrps_pkg::*;
#(
    parameter int PID_COUNT = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [PID_W-1:0] i_pid_index,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_grant_valid,
    output logic [PID_W-1:0] o_grant_index,
    output logic             o_edge_change,
    output logic             o_count_error
);

    localparam int IW = $clog2(PID_COUNT);
    localparam int LW = $clog2(PID_COUNT + 1);
    localparam logic [LW-1:0] LAST_NONE = LW'(PID_COUNT);
    localparam t_sum          PID_LIMIT = ADD_W'(PID_COUNT);
    localparam logic [IW-1:0] STEP_LAST = IW'(PID_COUNT - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PUSH = 3'd3;

    logic [2:0]           r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [IW-1:0]        r_addr, n_addr;
    logic [IW-1:0]        r_probe, n_probe;
    logic [IW-1:0]        r_step, n_step;
    logic [LW-1:0]        r_last, n_last;
    logic [PID_COUNT-1:0] r_nz, n_nz;

    logic                 r_res_gv, n_res_gv;
    logic [PID_W-1:0]     r_res_gi, n_res_gi;
    logic                 r_res_edge, n_res_edge;
    logic                 r_res_err, n_res_err;

    logic                 r_o_valid, n_o_valid;
    logic                 r_o_gv;
    logic [PID_W-1:0]     r_o_gi;
    logic                 r_o_edge;
    logic                 r_o_err;
    logic                 w_load_out;

    logic                 w_accept;
    t_sum                 w_idx_ext;
    logic                 w_idx_ok;
    t_sum                 w_add_a;
    t_sum                 w_add_b;
    t_sum                 w_sum;
    logic                 w_wrap;
    t_count               w_rdata;
    t_count               w_count;
    logic                 w_sat;
    logic                 w_we;
    t_sum                 w_probe_ext;

    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_idx_ext = ADD_W'(i_pid_index);
    assign w_idx_ok  = (w_idx_ext < PID_LIMIT);

    // current count: zero until the entry has been written nonzero
    assign w_count = r_nz[r_addr] ? w_rdata : '0;
    assign w_sat   = (r_cmd == CMD_SUBSCRIBE) ? (w_count == COUNT_MAX) : (w_count == '0);
    assign w_we    = (r_state == S_READ) && !w_sat;

    // shared adder: last grant + 1 at poll start, count +/- 1, probe + 1 during scan
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_add_a = ADD_W'(r_last);
            S_READ:  w_add_a = ADD_W'(w_count);
            S_SCAN:  w_add_a = ADD_W'(r_probe);
            default: w_add_a = '0;
        endcase
    end
    assign w_add_b = ((r_state == S_READ) && (r_cmd == CMD_UNSUBSCRIBE)) ? '1 : t_sum'(1);
    assign w_sum   = w_add_a + w_add_b;
    assign w_wrap  = (w_sum >= PID_LIMIT);
    assign w_probe_ext = ADD_W'(r_probe);

    rrps_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (PID_COUNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_sum[COUNT_W-1:0]),
        .i_re    (w_accept),
        .i_raddr (w_idx_ext[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_load_out = (r_state == S_PUSH) && (!r_o_valid || i_ready);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_probe    = r_probe;
        n_step     = r_step;
        n_last     = r_last;
        n_nz       = r_nz;
        n_res_gv   = r_res_gv;
        n_res_gi   = r_res_gi;
        n_res_edge = r_res_edge;
        n_res_err  = r_res_err;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd      = i_cmd;
                    n_addr     = w_idx_ext[IW-1:0];
                    n_step     = '0;
                    n_res_gv   = 1'b0;
                    n_res_gi   = '0;
                    n_res_edge = 1'b0;
                    n_res_err  = 1'b0;
                    if (i_cmd == CMD_POLL) begin
                        // from none the scan begins at identifier 1
                        if (r_last == LAST_NONE) begin
                            n_probe = IW'(1);
                        end else if (w_wrap) begin
                            n_probe = '0;
                        end else begin
                            n_probe = w_sum[IW-1:0];
                        end
                        n_state = S_SCAN;
                    end else if ((i_cmd == CMD_SUBSCRIBE || i_cmd == CMD_UNSUBSCRIBE)
                                 && w_idx_ok) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_READ: begin
                n_res_err = w_sat;
                if (!w_sat) begin
                    n_nz[r_addr] = (w_sum[COUNT_W-1:0] != '0);
                    n_res_edge   = (r_cmd == CMD_SUBSCRIBE) ? (w_count == '0)
                                                            : (w_count == t_count'(1));
                end
                n_state = S_PUSH;
            end
            S_SCAN: begin
                if (r_nz[r_probe]) begin
                    n_last   = LW'(r_probe);
                    n_res_gv = 1'b1;
                    n_res_gi = w_probe_ext[PID_W-1:0];
                    n_state  = S_PUSH;
                end else if (r_step == STEP_LAST) begin
                    n_last  = LAST_NONE;
                    n_state = S_PUSH;
                end else begin
                    n_probe = w_wrap ? '0 : w_sum[IW-1:0];
                    n_step  = r_step + IW'(1);
                end
            end
            S_PUSH: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (w_load_out) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= LAST_NONE;
            r_nz      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_nz      <= n_nz;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_probe    <= n_probe;
        r_step     <= n_step;
        r_res_gv   <= n_res_gv;
        r_res_gi   <= n_res_gi;
        r_res_edge <= n_res_edge;
        r_res_err  <= n_res_err;
        if (w_load_out) begin
            r_o_gv   <= r_res_gv;
            r_o_gi   <= r_res_gi;
            r_o_edge <= r_res_edge;
            r_o_err  <= r_res_err;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_grant_valid = r_o_gv;
    assign o_grant_index = r_o_gi;
    assign o_edge_change = r_o_edge;
    assign o_count_error = r_o_err;

endmodule
